### rtl/lpt_pkg.sv
// Types and constants shared by the long-press tracker modules.
package lpt_pkg;

  localparam int BUTTON_W     = 16;
  localparam int FUNCTION_W   = 12;
  localparam int SCOPE_W      = 8;
  localparam int FRAMES_W     = 25;
  localparam int THRESHOLD_W  = 24;
  localparam int TICK_W       = 16;
  localparam int REPEAT_W     = 8;
  localparam int MAX_NOTES    = 8;
  localparam int NOTE_CNT_W   = $clog2(MAX_NOTES);
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 24'd44100;
  localparam logic [REPEAT_W-1:0]    REPEAT_MAX      = 8'd255;

  typedef struct packed {
    logic                  cmd;
    logic [BUTTON_W-1:0]   button_id;
    logic                  is_release;
    logic                  sustain_capable;
    logic                  long_pressable;
    logic [FUNCTION_W-1:0] function_id;
    logic [SCOPE_W-1:0]    scope_track;
    logic [TICK_W-1:0]     tick_frames;
  } req_item_t;

  typedef struct packed {
    logic [FUNCTION_W-1:0] function_id_out;
    logic [SCOPE_W-1:0]    scope_track_out;
    logic [REPEAT_W-1:0]   repeat_count;
    logic                  last;
  } rsp_item_t;

  typedef struct packed {
    logic                  valid;
    logic [BUTTON_W-1:0]   button;
    logic [FUNCTION_W-1:0] func;
    logic [SCOPE_W-1:0]    scope;
    logic [FRAMES_W-1:0]   frames;
    logic [REPEAT_W-1:0]   repeats;
  } entry_t;

  typedef struct packed {
    logic                  hit;
    logic [FUNCTION_W-1:0] func;
    logic [SCOPE_W-1:0]    scope;
    logic [REPEAT_W-1:0]   repeats;
  } note_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_UPDATE,
    OP_TICK,
    OP_DRAIN
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [BUTTON_W-1:0]    button;
    logic [FUNCTION_W-1:0]  func;
    logic [TICK_W-1:0]      tick_frames;
    logic [THRESHOLD_W-1:0] threshold;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_TICK,
    S_DRAIN
  } lpt_state_t;

endpackage

### rtl/long_press_tracker.sv
// Top level of the long-press tracker: control sequencer, cell chain and result register.
// Held buttons sit in a chain of POOL cells kept in recency order, newest in cell 0, so a
// new press shifts the chain down and a release closes the gap behind the freed cell. A
// button event is the accept beat followed by one chain update. A tick is the accept beat, then
// a step that adds the frames and latches notifications in every cell, then the notifications
// shift out of cell 0 one a cycle while the result side does not stall. At most eight results
// leave per tick, the final one marked last. The threshold resets to 44100; the user must write
// it through the cfg channel only while idle, as the block itself does not enforce this.
module long_press_tracker #(
  parameter int POOL = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  lpt_pkg::req_item_t                  req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output lpt_pkg::rsp_item_t                  rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpt_pkg::THRESHOLD_W-1:0]     cfg_data
);
  import lpt_pkg::*;

  localparam int IDX_W = (POOL > 1) ? $clog2(POOL) : 1;

  lpt_state_t             state, state_next;
  req_item_t              item;
  logic [THRESHOLD_W-1:0] threshold;
  logic [NOTE_CNT_W-1:0]  emitted, emitted_next;

  cell_cmd_t         cmd;
  cell_op_t          op;
  entry_t            entries [POOL];
  note_t             notes   [POOL];
  entry_t            new_entry;
  entry_t            empty_entry;
  note_t             empty_note;
  logic [POOL-1:0]   match_vec;
  logic [POOL-1:0]   hit_vec;
  logic [POOL-1:0]   valid_vec;
  logic [POOL-1:0]   sel_ge;
  logic [POOL-1:0]   sel;
  logic [IDX_W-1:0]  pos;
  logic              qualifies;
  logic              found;
  logic              full;
  logic              any_hit;
  logic              rest_hit;
  logic              out_free;
  logic              load;
  logic              load_last;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      emitted <= '0;
    end else begin
      state   <= state_next;
      emitted <= emitted_next;
    end
  end

  assign new_entry   = '{valid: 1'b1, button: item.button_id, func: item.function_id,
                         scope: item.scope_track, frames: '0, repeats: '0};
  assign empty_entry = '0;
  assign empty_note  = '0;

  assign cmd = '{op: op, button: item.button_id, func: item.function_id,
                 tick_frames: item.tick_frames, threshold: threshold};

  for (genvar k = 0; k < POOL; k++) begin : g_cell
    lpt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .sel        (sel[k]),
      .prev_entry ((k == 0) ? new_entry : entries[(k == 0) ? 0 : k - 1]),
      .next_entry ((k == POOL - 1) ? empty_entry : entries[(k == POOL - 1) ? k : k + 1]),
      .next_note  ((k == POOL - 1) ? empty_note : notes[(k == POOL - 1) ? k : k + 1]),
      .entry      (entries[k]),
      .note       (notes[k]),
      .match      (match_vec[k])
    );
    assign hit_vec[k]   = notes[k].hit;
    assign valid_vec[k] = entries[k].valid;
  end

  // ids are unique in the chain, so the match is one-hot and an OR encoder suffices
  always_comb begin
    pos = '0;
    for (int k = 0; k < POOL; k++) begin
      if (match_vec[k]) begin
        pos = pos | IDX_W'(k);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < POOL; k++) begin
      sel_ge[k] = IDX_W'(k) >= pos;
    end
  end

  assign qualifies = item.long_pressable && item.sustain_capable && (item.button_id != '0);
  assign found     = |match_vec;
  assign full      = entries[POOL-1].valid;
  assign any_hit   = |hit_vec;
  assign rest_hit  = |(hit_vec >> 1);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next   = state;
    emitted_next = emitted;
    op           = OP_HOLD;
    sel          = '0;
    load         = 1'b0;
    load_last    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = req.cmd ? S_TICK : S_FIND;
        end
      end
      S_FIND: begin
        state_next = S_IDLE;
        if (qualifies) begin
          if (found) begin
            if (item.is_release) begin
              op  = OP_REMOVE;
              sel = sel_ge;
            end else begin
              op  = OP_UPDATE;
              sel = match_vec;
            end
          end else if (!item.is_release && !full) begin
            op = OP_INSERT;
          end
        end
      end
      S_TICK: begin
        op           = OP_TICK;
        emitted_next = '0;
        state_next   = S_DRAIN;
      end
      S_DRAIN: begin
        if (!any_hit) begin
          state_next = S_IDLE;
        end else if (hit_vec[0]) begin
          if (out_free) begin
            load         = 1'b1;
            load_last    = !rest_hit || (emitted == NOTE_CNT_W'(MAX_NOTES - 1));
            op           = OP_DRAIN;
            emitted_next = emitted + 1'b1;
            if (load_last) begin
              state_next = S_IDLE;
            end
          end
        end else begin
          op = OP_DRAIN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= '{function_id_out: notes[0].func, scope_track_out: notes[0].scope,
               repeat_count: notes[0].repeats, last: load_last};
    end
  end

  a_held_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("held entries not packed at the head of the chain");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |-> $onehot0(match_vec))
    else $error("button id held in more than one cell");

  a_note_limit: assert property (@(posedge clk) disable iff (rst)
    (load && (emitted == NOTE_CNT_W'(MAX_NOTES - 1))) |-> load_last)
    else $error("tick result limit passed without last");

endmodule

### rtl/lpt_cell.sv
// One tracker cell: a held entry in recency position plus its pending notification.
module lpt_cell (
  input  logic              clk,
  input  logic              rst,
  input  lpt_pkg::cell_cmd_t cmd,
  input  logic              sel,
  input  lpt_pkg::entry_t   prev_entry,
  input  lpt_pkg::entry_t   next_entry,
  input  lpt_pkg::note_t    next_note,
  output lpt_pkg::entry_t   entry,
  output lpt_pkg::note_t    note,
  output logic              match
);
  import lpt_pkg::*;

  logic [FRAMES_W-1:0] sum;
  logic                reached;
  logic [REPEAT_W-1:0] repeats_inc;

  assign match       = entry.valid && (entry.button == cmd.button);
  assign sum         = entry.frames + FRAMES_W'(cmd.tick_frames);
  assign reached     = sum >= FRAMES_W'(cmd.threshold);
  assign repeats_inc = (entry.repeats == REPEAT_MAX) ? entry.repeats : entry.repeats + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
      note.hit    <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_HOLD: begin
        end
        OP_INSERT: begin
          entry <= prev_entry;
        end
        OP_REMOVE: begin
          if (sel) begin
            entry <= next_entry;
          end
        end
        OP_UPDATE: begin
          if (sel) begin
            entry.frames <= '0;
            entry.func   <= cmd.func;
          end
        end
        OP_TICK: begin
          note.func    <= entry.func;
          note.scope   <= entry.scope;
          note.repeats <= entry.repeats;
          note.hit     <= entry.valid && reached;
          if (entry.valid) begin
            if (reached) begin
              entry.frames  <= '0;
              entry.repeats <= repeats_inc;
            end else begin
              entry.frames <= sum;
            end
          end
        end
        OP_DRAIN: begin
          note <= next_note;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### tb/sv/long_press_checker.sv
`timescale 1ns / 1ps
// Checker for the long-press tracker: mirrors the held-button table and compares notifications.
package lpt_tb_pkg;
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;
endpackage

module long_press_checker #(
  parameter int POOL = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  lpt_pkg::req_item_t              req,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  lpt_pkg::rsp_item_t              rsp,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lpt_pkg::THRESHOLD_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              notes_seen
);
  import lpt_pkg::*;
  import lpt_tb_pkg::*;

  logic [THRESHOLD_W-1:0] threshold;
  bit                     slot_held [POOL];
  logic [BUTTON_W-1:0]    slot_button [POOL];
  logic [FUNCTION_W-1:0]  slot_func [POOL];
  logic [SCOPE_W-1:0]     slot_scope [POOL];
  logic [FRAMES_W-1:0]    slot_count [POOL];
  logic [REPEAT_W-1:0]    slot_repeats [POOL];
  int                     recency[$];        // slot numbers, newest first
  rsp_item_t              expected_notes[$];
  int                     fail_count = 0;
  int                     note_count = 0;

  function automatic void apply_button(req_item_t it);
    int pos = -1;
    int free_slot = -1;
    if (!it.long_pressable || !it.sustain_capable || it.button_id == '0) return;
    for (int k = 0; k < recency.size(); k++) begin
      if (pos < 0 && slot_button[recency[k]] == it.button_id) pos = k;
    end
    if (pos < 0) begin
      if (it.is_release || recency.size() >= POOL) return;
      for (int k = 0; k < POOL; k++) begin
        if (free_slot < 0 && !slot_held[k]) free_slot = k;
      end
      if (free_slot < 0) return;
      slot_held[free_slot]    = 1'b1;
      slot_button[free_slot]  = it.button_id;
      slot_func[free_slot]    = it.function_id;
      slot_scope[free_slot]   = it.scope_track;
      slot_count[free_slot]   = '0;
      slot_repeats[free_slot] = '0;
      recency.push_front(free_slot);
    end else if (it.is_release) begin
      slot_held[recency[pos]] = 1'b0;
      recency.delete(pos);
    end else begin
      slot_count[recency[pos]] = '0;
      slot_func[recency[pos]]  = it.function_id;
    end
  endfunction

  function automatic void apply_tick(req_item_t it);
    rsp_item_t notes [MAX_NOTES];
    int        n = 0;
    int        s;
    for (int k = 0; k < recency.size(); k++) begin
      s = recency[k];
      slot_count[s] = slot_count[s] + it.tick_frames;
      if (slot_count[s] >= {1'b0, threshold}) begin
        if (n < MAX_NOTES) begin
          notes[n].function_id_out = slot_func[s];
          notes[n].scope_track_out = slot_scope[s];
          notes[n].repeat_count    = slot_repeats[s];
          notes[n].last            = 1'b0;
          n++;
        end
        slot_count[s] = '0;
        if (slot_repeats[s] != REPEAT_MAX) slot_repeats[s] = slot_repeats[s] + 1'b1;
      end
    end
    if (n > 0) notes[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_notes.push_back(notes[k]);
  endfunction

  task automatic record_failure(bit orphan, rsp_item_t got, rsp_item_t want);
    fail_count++;
    if (fail_count <= 10) begin
      if (orphan)
        $display("%0t: notification with none expected: fn=%h scope=%h rep=%0d last=%b",
                 $time, got.function_id_out, got.scope_track_out, got.repeat_count,
                 got.last);
      else
        $display("%0t: notification mismatch: expected fn=%h scope=%h rep=%0d last=%b, %s",
                 $time, want.function_id_out, want.scope_track_out, want.repeat_count,
                 want.last,
                 $sformatf("got fn=%h scope=%h rep=%0d last=%b", got.function_id_out,
                           got.scope_track_out, got.repeat_count, got.last));
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_item_t want;
    if (rst) begin
      threshold = THRESHOLD_RESET;
      for (int k = 0; k < POOL; k++) slot_held[k] = 1'b0;
      recency.delete();
      expected_notes.delete();
    end else begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        note_count++;
        if (expected_notes.size() == 0) begin
          record_failure(1'b1, rsp, rsp);
        end else begin
          want = expected_notes.pop_front();
          if (rsp.function_id_out !== want.function_id_out ||
              rsp.scope_track_out !== want.scope_track_out ||
              rsp.repeat_count !== want.repeat_count || rsp.last !== want.last)
            record_failure(1'b0, rsp, want);
        end
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) threshold = cfg_data;
      if (req_valid === 1'b1 && req_stall === 1'b0) begin
        if (req.cmd == CMD_TICK) apply_tick(req);
        else apply_button(req);
      end
    end
    mismatches <= fail_count;
    pending    <= expected_notes.size();
    notes_seen <= note_count;
  end

endmodule

### tb/sv/tb_long_press_tracker.sv
`timescale 1ns / 1ps
// Testbench top for the long-press tracker: clock, reset, stimulus, receiver stalls and verdict.
module tb_long_press_tracker;
  import lpt_pkg::*;
  import lpt_tb_pkg::*;

  localparam int POOL         = 8;
  localparam int SETTLE       = 20;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_BEATS  = 28;
  localparam int SAT_TICKS    = 20;
  localparam int N_IDS        = 12;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  req_item_t              req = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  rsp_item_t              rsp;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [THRESHOLD_W-1:0] cfg_data = '0;

  int mismatches;
  int pending;
  int notes_seen;
  int hold_requests = 0;
  int holds_served  = 0;
  int beats_sent    = 0;
  int ticks_sent    = 0;
  int settings      = 0;

  logic [BUTTON_W-1:0] ids [N_IDS];

  always #10 clk = ~clk;

  long_press_tracker #(.POOL(POOL)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  long_press_checker #(.POOL(POOL)) i_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .notes_seen (notes_seen)
  );

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stall patterns, with a long hold-off whenever one is requested
  initial begin : receiver
    int len;
    int mode;
    forever begin
      if (holds_served < hold_requests) begin
        @(posedge clk);
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
        holds_served++;
      end else begin
        len  = $urandom_range(1, 40);
        mode = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) begin
          @(posedge clk);
          case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= 1'($urandom_range(0, 1));
            3: rsp_stall <= i[0];
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  function automatic req_item_t button_beat(logic [BUTTON_W-1:0] id, logic up,
                                            logic [FUNCTION_W-1:0] fn,
                                            logic [SCOPE_W-1:0] sc);
    req_item_t it;
    it.cmd             = CMD_EVENT;
    it.button_id       = id;
    it.is_release      = up;
    it.sustain_capable = 1'b1;
    it.long_pressable  = 1'b1;
    it.function_id     = fn;
    it.scope_track     = sc;
    it.tick_frames     = TICK_W'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic req_item_t tick_beat(logic [TICK_W-1:0] frames);
    logic [63:0] raw;
    req_item_t   it;
    raw            = {$urandom, $urandom};
    it             = raw[$bits(req_item_t)-1:0];
    it.cmd         = CMD_TICK;
    it.tick_frames = frames;
    return it;
  endfunction

  // mostly well-formed presses, releases and ticks on a small id set; the rest is noise
  function automatic req_item_t random_item(int press_pct);
    logic [63:0] raw;
    req_item_t   it;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      it = tick_beat(TICK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(0, 65535)));
    end else if (r < 40 + press_pct) begin
      it = button_beat(ids[$urandom_range(0, N_IDS-1)], 1'b0,
                       FUNCTION_W'($urandom_range(0, 4095)),
                       SCOPE_W'($urandom_range(0, 255)));
    end else if (r < 88) begin
      it = button_beat(ids[$urandom_range(0, N_IDS-1)], 1'b1,
                       FUNCTION_W'($urandom_range(0, 4095)),
                       SCOPE_W'($urandom_range(0, 255)));
    end else begin
      raw    = {$urandom, $urandom};
      it     = raw[$bits(req_item_t)-1:0];
      it.cmd = CMD_EVENT;
    end
    return it;
  endfunction

  task automatic offer_beat(req_item_t it);
    req       <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    beats_sent++;
    if (it.cmd == CMD_TICK) ticks_sent++;
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THRESHOLD_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic random_bursts(int count, int press_pct);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++) begin
        offer_beat(random_item(press_pct));
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    req_item_t              it;
    logic [THRESHOLD_W-1:0] phase_thresholds [7];
    for (int k = 0; k < 9; k++) ids[k] = BUTTON_W'(k + 1);
    ids[9]  = 16'hFFFF;
    ids[10] = BUTTON_W'($urandom_range(16'h0100, 16'hFFFE));
    ids[11] = BUTTON_W'($urandom_range(16'h0100, 16'hFFFE));
    phase_thresholds = '{24'd1, 24'd0, 24'hFFFFFF, 24'd5000, 24'd70000, 24'd44100,
                         24'd0};
    phase_thresholds[6] = THRESHOLD_W'($urandom_range(100, 200000));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: default threshold, field extremes, ignored events, update, full table
    offer_beat(button_beat(16'h0001, 1'b0, 12'hFFF, 8'hFF));
    offer_beat(button_beat(16'hFFFF, 1'b0, 12'h000, 8'h00));
    it = button_beat(16'h0002, 1'b0, 12'h123, 8'h01);
    it.long_pressable = 1'b0;
    offer_beat(it);
    it = button_beat(16'h0003, 1'b0, 12'h456, 8'h02);
    it.sustain_capable = 1'b0;
    offer_beat(it);
    offer_beat(button_beat(16'h0000, 1'b0, 12'h789, 8'h03));
    offer_beat(button_beat(16'h1234, 1'b1, 12'hABC, 8'h04));
    offer_beat(tick_beat(16'hFFFF));
    offer_beat(tick_beat(16'h0000));
    offer_beat(button_beat(16'h0001, 1'b0, 12'h0AB, 8'h12));
    offer_beat(tick_beat(16'd44099));
    offer_beat(tick_beat(16'd1));
    it = button_beat(16'hFFFF, 1'b1, 12'h000, 8'h00);
    it.long_pressable = 1'b0;
    offer_beat(it);
    offer_beat(button_beat(16'hFFFF, 1'b1, 12'h000, 8'h00));
    for (int k = 2; k <= 9; k++)
      offer_beat(button_beat(k[BUTTON_W-1:0], 1'b0, FUNCTION_W'($urandom_range(0, 4095)),
                             SCOPE_W'($urandom_range(0, 255))));
    offer_beat(tick_beat(16'hFFFF));
    offer_beat(button_beat(16'h0005, 1'b1, 12'h000, 8'h00));
    offer_beat(tick_beat(16'hFFFF));
    drain_results();

    for (int ph = 0; ph < 7; ph++) begin
      write_threshold(phase_thresholds[ph]);
      if (ph == 0) hold_requests++;
      random_bursts(PHASE_BEATS, (ph == 2) ? 45 : 25);
      drain_results();
    end

    // repeat counts climbing: eight fresh holds, a notification on every tick
    write_threshold(24'd1);
    for (int k = 0; k < N_IDS; k++)
      offer_beat(button_beat(ids[k], 1'b1, 12'h000, 8'h00));
    for (int k = 0; k < POOL; k++)
      offer_beat(button_beat(ids[k], 1'b0, FUNCTION_W'($urandom_range(0, 4095)),
                             SCOPE_W'($urandom_range(0, 255))));
    for (int k = 0; k < SAT_TICKS; k++) begin
      offer_beat(tick_beat(TICK_W'($urandom_range(1, 65535))));
      if ($urandom_range(0, 15) == 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
    drain_results();

    $display("Run covered %0d input beats (%0d ticks) across %0d threshold writes",
             beats_sent, ticks_sent, settings);
    $display("%0d notifications checked, incl. full table, long hold-off and repeat counts",
             notes_seen);
    if (mismatches == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
